// ----- hdl/lfa_pkg.sv -----
// Shared constants, codes and types of the lowest-free identifier allocator.
package lfa_pkg;

  // Pool geometry
  localparam int POOL_SIZE = 256;
  localparam int POOL_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int ID_W      = 16;

  // Search tree: groups of sixteen slots, then a pick over the groups
  localparam int GRP_SIZE  = 16;
  localparam int GRP_W     = 4;
  localparam int NGRP      = (POOL_SIZE + GRP_SIZE - 1) / GRP_SIZE;
  localparam int NGRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD_SIZE  = NGRP * GRP_SIZE;
  localparam int SLOT_W    = NGRP_W + GRP_W;

  // Stream widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_CURRENT = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_EXHAUSTED  = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // latch item and first search stage
    logic exec;   // finish operation, update state, fill output register
  } cmd_t;

endpackage

// ----- hdl/lfa_ctrl.sv -----
// Controller: item sequencing and output valid tracking.
module lfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output lfa_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  // Commands
  always_comb begin
    cmd.load = s_tvalid && (state == S_IDLE);
    cmd.exec = (state == S_EXEC) && (!out_valid || m_tready);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hdl/lfa_dpath.sv -----
// Datapath: used-map, two-stage lowest-free search, release check, result register.
module lfa_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  lfa_pkg::cmd_t                    cmd,
  input  logic [lfa_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             cfg_write,
  input  logic [lfa_pkg::ID_W-1:0]         cfg_data,
  output logic [lfa_pkg::OUT_DATA_W-1:0]   m_tdata
);

  // Architectural state
  logic [lfa_pkg::POOL_SIZE-1:0] used_map;
  logic                          cur_valid;
  logic [lfa_pkg::ID_W-1:0]      cur_id;
  logic [lfa_pkg::ID_W-1:0]      first_id;

  // Latched item
  lfa_pkg::op_t             op_q;
  logic [lfa_pkg::ID_W-1:0] id_q;

  // First search stage registers
  logic [lfa_pkg::NGRP-1:0]    grp_any, grp_any_q;
  logic [lfa_pkg::GRP_W-1:0]   grp_off   [lfa_pkg::NGRP];
  logic [lfa_pkg::GRP_W-1:0]   grp_off_q [lfa_pkg::NGRP];

  // Result register and the value it loads
  logic [lfa_pkg::ID_W-1:0] out_id;
  lfa_pkg::status_t         out_status;
  logic [lfa_pkg::ID_W-1:0] res_id;
  lfa_pkg::status_t         res_status;

  // Slots that may be handed out: free and not past the top of the id space
  logic [lfa_pkg::ID_W-1:0]      max_slot;
  logic                          max_hi_nz;
  logic [lfa_pkg::POOL_SIZE-1:0] avail;
  logic [lfa_pkg::PAD_SIZE-1:0]  avail_pad;

  assign max_slot  = 16'hFFFF - first_id;
  assign max_hi_nz = |(max_slot >> lfa_pkg::POOL_W);

  always_comb begin
    for (int i = 0; i < lfa_pkg::POOL_SIZE; i++) begin
      avail[i] = !used_map[i] &&
                 (max_hi_nz || (lfa_pkg::POOL_W'(i) <= max_slot[lfa_pkg::POOL_W-1:0]));
    end
    avail_pad = '0;
    avail_pad[lfa_pkg::POOL_SIZE-1:0] = avail;
  end

  // Stage one: per-group any-free flag and lowest free offset
  always_comb begin
    for (int g = 0; g < lfa_pkg::NGRP; g++) begin
      grp_any[g] = |avail_pad[g*lfa_pkg::GRP_SIZE +: lfa_pkg::GRP_SIZE];
      grp_off[g] = '0;
      for (int b = lfa_pkg::GRP_SIZE - 1; b >= 0; b--) begin
        if (avail_pad[g*lfa_pkg::GRP_SIZE + b]) grp_off[g] = lfa_pkg::GRP_W'(b);
      end
    end
  end

  // Stage two: lowest group that has a free slot
  logic                       found;
  logic [lfa_pkg::NGRP_W-1:0] sel_grp;
  logic [lfa_pkg::SLOT_W-1:0] alloc_slot;
  logic [lfa_pkg::ID_W-1:0]   alloc_id;

  always_comb begin
    found   = 1'b0;
    sel_grp = '0;
    for (int g = lfa_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found   = 1'b1;
        sel_grp = lfa_pkg::NGRP_W'(g);
      end
    end
    alloc_slot = {sel_grp, grp_off_q[sel_grp]};
    alloc_id   = first_id + lfa_pkg::ID_W'(alloc_slot);
  end

  // Release lookup
  logic [lfa_pkg::ID_W:0]     rel_diff;
  logic                       rel_in_range;
  logic [lfa_pkg::POOL_W-1:0] rel_slot;
  logic                       rel_hit;

  assign rel_diff     = {1'b0, id_q} - {1'b0, first_id};
  assign rel_in_range = !rel_diff[lfa_pkg::ID_W] &&
                        (rel_diff < (lfa_pkg::ID_W+1)'(lfa_pkg::POOL_SIZE));
  assign rel_slot     = rel_diff[lfa_pkg::POOL_W-1:0];
  assign rel_hit      = rel_in_range && used_map[rel_slot];

  // Item latch and first search stage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= lfa_pkg::op_t'(s_tdata[1:0]);
      id_q      <= s_tdata[17:2];
      grp_any_q <= grp_any;
      grp_off_q <= grp_off;
    end
  end

  // Architectural state update
  always_ff @(posedge clk) begin
    if (rst) begin
      used_map  <= '0;
      cur_valid <= 1'b0;
      cur_id    <= '0;
      first_id  <= '0;
    end else begin
      if (cfg_write) first_id <= cfg_data;
      if (cmd.exec) begin
        unique case (op_q)
          lfa_pkg::OP_ALLOC: begin
            if (found) begin
              used_map[alloc_slot[lfa_pkg::POOL_W-1:0]] <= 1'b1;
              cur_valid <= 1'b1;
              cur_id    <= alloc_id;
            end
          end
          lfa_pkg::OP_RELEASE: begin
            if (rel_hit) begin
              used_map[rel_slot] <= 1'b0;
              if (cur_valid && (cur_id == id_q)) begin
                cur_valid <= 1'b0;
                cur_id    <= '0;
              end
            end
          end
          lfa_pkg::OP_QUERY: ;
          lfa_pkg::OP_CLEAR: begin
            used_map  <= '0;
            cur_valid <= 1'b0;
            cur_id    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Result value of the operation in work
  always_comb begin
    res_id     = '0;
    res_status = lfa_pkg::ST_OK;
    unique case (op_q)
      lfa_pkg::OP_ALLOC: begin
        if (found) res_id = alloc_id;
        else res_status = lfa_pkg::ST_EXHAUSTED;
      end
      lfa_pkg::OP_RELEASE: begin
        if (!rel_hit) res_status = lfa_pkg::ST_NOT_FOUND;
      end
      lfa_pkg::OP_QUERY: begin
        if (cur_valid) res_id = cur_id;
        else res_status = lfa_pkg::ST_NO_CURRENT;
      end
      lfa_pkg::OP_CLEAR: ;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_id     <= res_id;
      out_status <= res_status;
    end
  end

  assign m_tdata = {6'b0, out_status, out_id};

endmodule

// ----- hdl/lowest_free_id_allocator.sv -----
// Top level of the lowest-free identifier allocator.
//
//  Channel  Dir  Handshake             Payload
//  s_*      in   s_tvalid / s_tready   s_tdata: op [1:0], id_in [17:2]
//  m_*      out  m_tvalid / m_tready   m_tdata: id_out [15:0], status [17:16]
//  cfg_*    in   cfg_valid / cfg_ready cfg_data: first_id
//
// On accept the per-group free search over the used-map is registered;
// in the execute state the block then picks the lowest group, updates
// the map and loads the result register.
// The result register frees the input side: a new item is taken while a
// result waits; only the execute step stalls on a full result register.
// Synchronous reset frees every identifier, drops the current one and
// sets first_id to zero; no clearing pass is needed.
module lowest_free_id_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // op [1:0], id_in [17:2], zero [23:18]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // id_out [15:0], status [17:16], zero [23:18]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  lfa_pkg::cmd_t cmd;

  // Config is always taken; the user must send it only while the block is idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  lfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lfa_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- hdl/lfa_checker.sv -----
// Port-level checks of the allocator and their bind to the top level.
module lfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A waiting result holds its value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Any failing status carries a zero identifier
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[17:16] != lfa_pkg::ST_OK) |-> m_tdata[15:0] == 16'd0)
    else $error("nonzero id with failing status");

  // Pad bits of the result stay zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:18] == 6'd0)
    else $error("result pad bits set");

  // One item in work at a time: input closes after an accept
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

endmodule

bind lowest_free_id_allocator lfa_checker u_lfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
